@@ rtl/core/lfu_pkg.sv @@
// Shared types and constants for the LFU cache replacement block.
// Request/response payloads, controller-datapath command and status structs.
// No dependencies.
package lfu_pkg;

    localparam int KEY_W          = 64;
    localparam int STAMP_W        = 48;
    localparam int CAP_W          = 7;
    localparam int ENTRIES_DEF    = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request action codes
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic             evicted_valid;
        logic [KEY_W-1:0] evicted_key;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;   // write one invalid entry, advance address
        logic load;    // capture request, restart scan
        logic scan;    // read one entry, advance address
        logic commit;  // write back the decision, load the response
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic addr_last;
        logic rsp_free;
    } stat_t;

endpackage

@@ rtl/core/lfu_fifo_replacement.sv @@
// Top level of the LFU cache replacement block with FIFO tie-break.
// Joins lfu_ctrl and lfu_datapath; depends on lfu_pkg.
//
//   channel  signals                      direction  payload
//   req      req_valid/req_ready/req      in         action, key
//   rsp      rsp_valid/rsp_ready/rsp      out        hit, evicted_valid, evicted_key
//   cfg      cfg_valid/cfg_ready/cfg_data in         capacity_in_use
//
// Each request passes through intake, a scan that reads one entry per cycle
// over all ENTRIES entries through the single read port of the entry
// memory, a drain step and a commit step.
// After reset a clearing pass over all ENTRIES entries invalidates every entry;
// req_ready stays low meanwhile. Capacity writes are taken at any time.
// A response waiting on rsp_ready does not block the next request; the
// commit of that next one holds until the response register is free.
module lfu_fifo_replacement #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  lfu_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output lfu_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);
    import lfu_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfu_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Busy after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on consecutive cycles");

    // Commit only into a free response register
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.rsp_free)
        else $error("commit overwrote a pending response");

    // Commit presents a response next cycle
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid)
        else $error("commit produced no response");

    // No eviction reported together with a hit
    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !(rsp.hit && rsp.evicted_valid))
        else $error("response reports hit and eviction");

endmodule

@@ rtl/core/lfu_ctrl.sv @@
// Sequencing FSM for the LFU cache: clearing pass, request intake,
// entry scan and commit. Depends on lfu_pkg.
module lfu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lfu_pkg::stat_t stat,
    output lfu_pkg::cmd_t  cmd
);
    import lfu_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the response register has room
                if (stat.rsp_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/core/lfu_datapath.sv @@
// Datapath for the LFU cache: entry memory, scan compare (match, victim,
// free slot), occupancy, sequence counter, capacity and response registers.
// Depends on lfu_pkg.
module lfu_datapath #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfu_pkg::cmd_t             cmd,
    output lfu_pkg::stat_t            stat,
    input  lfu_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output lfu_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);
    import lfu_pkg::*;

    localparam int AW    = $clog2(ENTRIES);
    localparam int OW    = $clog2(ENTRIES + 1);
    localparam int CW    = (OW > CAP_W) ? OW : CAP_W;
    localparam int REC_W = 1 + KEY_W + COUNT_BITS + STAMP_W;
    localparam int V_BIT = REC_W - 1;
    localparam int K_LSB = COUNT_BITS + STAMP_W;
    localparam int C_LSB = STAMP_W;

    localparam logic [AW-1:0]         ADDR_LAST = AW'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Entry memory: {valid, key, count, stamp}
    logic [REC_W-1:0] entry_mem [ENTRIES];
    logic [REC_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic             rd_live_reg;

    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    addr_next;
    logic [OW-1:0]    occ_reg;
    logic [OW-1:0]    occ_next;
    logic [STAMP_W-1:0] seq_reg;
    logic [STAMP_W-1:0] seq_next;
    logic [CAP_W-1:0] cap_reg;

    logic             act_reg;
    logic [KEY_W-1:0] key_reg;

    logic                  match_found_reg;
    logic [AW-1:0]         match_idx_reg;
    logic [COUNT_BITS-1:0] match_count_reg;
    logic                  free_found_reg;
    logic [AW-1:0]         free_idx_reg;
    logic                  best_found_reg;
    logic [AW-1:0]         best_idx_reg;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic [STAMP_W-1:0]    best_stamp_reg;
    logic [KEY_W-1:0]      best_key_reg;

    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [REC_W-1:0] wr_rec;

    logic                  rd_valid;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic [STAMP_W-1:0]    rd_stamp;
    logic                  better;

    logic [CW-1:0]         cap_eff;
    logic                  need_evict;
    logic [COUNT_BITS-1:0] count_inc;

    assign rd_valid = rd_data_reg[V_BIT];
    assign rd_key   = rd_data_reg[K_LSB +: KEY_W];
    assign rd_count = rd_data_reg[C_LSB +: COUNT_BITS];
    assign rd_stamp = rd_data_reg[STAMP_W-1:0];

    // Smaller count wins, then older stamp; ties keep the lower index
    assign better = !best_found_reg || (rd_count < best_count_reg) ||
                    ((rd_count == best_count_reg) && (rd_stamp < best_stamp_reg));

    // Clamp capacity to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(cap_reg) > CW'(ENTRIES))
        begin
            cap_eff = CW'(ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign need_evict = CW'(occ_reg) >= cap_eff;
    assign count_inc  = (match_count_reg == COUNT_MAX) ? match_count_reg
                                                       : match_count_reg + 1'b1;

    // Address counter shared by the clearing pass and the scan
    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.load)
        begin
            addr_next = '0;
        end
        else if (cmd.clear || cmd.scan)
        begin
            addr_next = (addr_reg == ADDR_LAST) ? '0 : addr_reg + 1'b1;
        end
    end

    // Decide the write-back and the response
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = addr_reg;
        wr_rec   = '0;
        occ_next = occ_reg;
        seq_next = seq_reg;
        rsp_next = '0;
        if (cmd.clear)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.commit)
        begin
            rsp_next.hit = match_found_reg;
            if (act_reg == ACT_REMOVE)
            begin
                // drop the entry if present
                if (match_found_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = match_idx_reg;
                    occ_next = occ_reg - 1'b1;
                end
            end
            else if (match_found_reg)
            begin
                // bump count, restamp as newest of its class
                wr_en    = 1'b1;
                wr_addr  = match_idx_reg;
                wr_rec   = {1'b1, key_reg, count_inc, seq_reg};
                seq_next = seq_reg + 1'b1;
            end
            else if (need_evict && best_found_reg)
            begin
                // replace the victim in place
                wr_en                  = 1'b1;
                wr_addr                = best_idx_reg;
                wr_rec                 = {1'b1, key_reg, COUNT_BITS'(1), seq_reg};
                seq_next               = seq_reg + 1'b1;
                rsp_next.evicted_valid = 1'b1;
                rsp_next.evicted_key   = best_key_reg;
            end
            else if (free_found_reg)
            begin
                // insert into the first free slot
                wr_en    = 1'b1;
                wr_addr  = free_idx_reg;
                wr_rec   = {1'b1, key_reg, COUNT_BITS'(1), seq_reg};
                seq_next = seq_reg + 1'b1;
                occ_next = occ_reg + 1'b1;
            end
        end
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_rec;
        end
        rd_data_reg <= entry_mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg        <= '0;
            occ_reg         <= '0;
            seq_reg         <= '0;
            cap_reg         <= CAP_RESET;
            rd_live_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else
        begin
            addr_reg    <= addr_next;
            occ_reg     <= occ_next;
            seq_reg     <= seq_next;
            rd_live_reg <= cmd.scan;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                best_found_reg  <= 1'b0;
            end
            else if (rd_live_reg)
            begin
                if (rd_valid && (rd_key == key_reg) && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (!rd_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (rd_valid && better)
                begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= req.action;
            key_reg <= req.key;
        end
        if (rd_live_reg)
        begin
            if (rd_valid && (rd_key == key_reg) && !match_found_reg)
            begin
                match_idx_reg   <= rd_idx_reg;
                match_count_reg <= rd_count;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (rd_valid && better)
            begin
                best_idx_reg   <= rd_idx_reg;
                best_count_reg <= rd_count;
                best_stamp_reg <= rd_stamp;
                best_key_reg   <= rd_key;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign stat.addr_last = (addr_reg == ADDR_LAST);
    assign stat.rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;
    assign cfg_ready      = 1'b1;

endmodule

@@ tb/lfu_fifo_replacement_tb.sv @@
// Self-checking testbench for lfu_fifo_replacement: directed and random requests
// checked against an in-bench LFU/FIFO store model. Depends on lfu_pkg and the
// RTL of the block only.
module lfu_fifo_replacement_tb;

    import lfu_pkg::*;

    localparam int NUM_ENTRIES = ENTRIES_DEF;
    // Narrow counts so saturation is reachable within a short run
    localparam int CNT_W       = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = NUM_ENTRIES + 8;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data;

    // Stimulus and scoreboard storage
    req_t                 request_q[$];
    rsp_t                 outcome_q[$];
    logic                 req_taken;
    int                   send_idle;
    int                   recv_idle;
    int                   mismatches;
    int                   cycles;

    // Shadow of the replacement store
    logic                 lfu_valid[NUM_ENTRIES];
    logic [KEY_W-1:0]     lfu_key[NUM_ENTRIES];
    logic [CNT_W-1:0]     lfu_count[NUM_ENTRIES];
    logic [STAMP_W-1:0]   lfu_stamp[NUM_ENTRIES];
    logic [STAMP_W-1:0]   lfu_seq;
    logic [CAP_W-1:0]     lfu_capacity;

    lfu_fifo_replacement #(
        .ENTRIES    (NUM_ENTRIES),
        .COUNT_BITS (CNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Run the clock
    always #5 clk = ~clk;

    // Apply one request to the shadow store and return the response it yields
    function automatic rsp_t lfu_apply(req_t r);
        int   found;
        int   used;
        int   victim;
        int   slot;
        int   limit;
        rsp_t o;
        o      = '0;
        found  = -1;
        used   = 0;
        victim = -1;
        slot   = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (lfu_valid[i])
            begin
                used++;
                if (found < 0 && lfu_key[i] == r.key)
                    found = i;
            end
        end
        if (r.action == ACT_REMOVE)
        begin
            if (found >= 0)
            begin
                lfu_valid[found] = 1'b0;
                o.hit = 1'b1;
            end
            return o;
        end
        if (found >= 0)
        begin
            // Hit: bump the count unless saturated, restamp as newest of its class
            if (lfu_count[found] != '1)
                lfu_count[found] = lfu_count[found] + 1'b1;
            lfu_stamp[found] = lfu_seq;
            lfu_seq = lfu_seq + 1'b1;
            o.hit = 1'b1;
            return o;
        end
        limit = int'(lfu_capacity);
        if (limit == 0)
            limit = 1;
        if (limit > NUM_ENTRIES)
            limit = NUM_ENTRIES;
        if (used >= limit)
        begin
            // Evict lowest count, oldest stamp among equals
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (lfu_valid[i] && (victim < 0 || lfu_count[i] < lfu_count[victim] ||
                    (lfu_count[i] == lfu_count[victim] && lfu_stamp[i] < lfu_stamp[victim])))
                    victim = i;
            end
            o.evicted_valid  = 1'b1;
            o.evicted_key    = lfu_key[victim];
            lfu_valid[victim] = 1'b0;
            slot = victim;
        end
        else
        begin
            for (int i = NUM_ENTRIES - 1; i >= 0; i--)
            begin
                if (!lfu_valid[i])
                    slot = i;
            end
        end
        lfu_valid[slot] = 1'b1;
        lfu_key[slot]   = r.key;
        lfu_count[slot] = CNT_W'(1);
        lfu_stamp[slot] = lfu_seq;
        lfu_seq = lfu_seq + 1'b1;
        return o;
    endfunction

    // Drive requests from the pending queue; hold valid until accepted
    always @(negedge clk)
    begin
        if (!req_valid || req_taken)
        begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                req_valid <= 1'b1;
                req       <= request_q.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Stall the response channel at random
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Check responses, then predict for newly accepted requests
    always @(posedge clk)
    begin
        rsp_t want;
        req_taken <= req_valid && req_ready;
        if (rsp_valid && rsp_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response hit=%0b ev_valid=%0b ev_key=%h",
                             rsp.hit, rsp.evicted_valid, rsp.evicted_key);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (rsp.hit !== want.hit || rsp.evicted_valid !== want.evicted_valid ||
                    rsp.evicted_key !== want.evicted_key)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: expected %0b %0b %h, got %0b %0b %h",
                                 want.hit, want.evicted_valid, want.evicted_key,
                                 rsp.hit, rsp.evicted_valid, rsp.evicted_key);
                end
            end
        end
        if (req_valid && req_ready)
            outcome_q.push_back(lfu_apply(req));
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_request(input logic act, input logic [KEY_W-1:0] k);
        req_t r;
        r.action = act;
        r.key    = k;
        request_q.push_back(r);
    endtask

    // Wait until every request is sent and every response is back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (request_q.size() != 0 || req_valid || outcome_q.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        lfu_capacity = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Queue random requests over a skewed pool of keys so hits and evictions both occur
    task automatic queue_random(input int count, input logic [CAP_W-1:0] cap);
        logic [KEY_W-1:0] pool[$];
        int               pool_n;
        int               eff;
        logic             act;
        logic [KEY_W-1:0] k;
        eff = (cap == 0) ? 1 : ((int'(cap) > NUM_ENTRIES) ? NUM_ENTRIES : int'(cap));
        pool_n = eff + eff / 2 + 2;
        for (int i = 0; i < pool_n; i++)
            pool.push_back({$urandom, $urandom});
        for (int i = 0; i < count; i++)
        begin
            act = ($urandom_range(0, 99) < 15) ? ACT_REMOVE : ACT_ACCESS;
            if ($urandom_range(0, 99) < 8)
                k = {$urandom, $urandom};
            else
                k = pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
            push_request(act, k);
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] caps[6];
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        rsp_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        req_taken  = 1'b0;
        mismatches = 0;
        cycles     = 0;
        send_idle  = 11;
        recv_idle  = 88;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            lfu_valid[i] = 1'b0;
            lfu_key[i]   = '0;
            lfu_count[i] = '0;
            lfu_stamp[i] = '0;
        end
        lfu_seq      = '0;
        lfu_capacity = CAP_RESET;

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: key extremes, hit, remove hit and miss, count saturation
        push_request(ACT_ACCESS, '0);
        push_request(ACT_ACCESS, '1);
        push_request(ACT_ACCESS, '0);
        push_request(ACT_REMOVE, '1);
        push_request(ACT_REMOVE, '1);
        push_request(ACT_ACCESS, {32{2'b01}});
        push_request(ACT_ACCESS, {32{2'b10}});
        repeat (14) push_request(ACT_ACCESS, '0);
        wait_drained();

        // Directed: capacity zero acts as one, below occupancy, FIFO among equal counts
        write_capacity(7'd0);
        push_request(ACT_ACCESS, 64'h0123_4567_89AB_CDEF);
        push_request(ACT_ACCESS, 64'hFEDC_BA98_7654_3210);
        push_request(ACT_ACCESS, 64'h0123_4567_89AB_CDEF);
        wait_drained();

        // Random phases over several capacities and idle patterns
        caps = '{7'd1, 7'd127, 7'd64, 7'd6, 7'd2, 7'd40};
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle = 11;
                recv_idle = 88;
            end
            else if (p < 4)
            begin
                send_idle = 88;
                recv_idle = 11;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_capacity(caps[p]);
            queue_random(84, caps[p]);
            wait_drained();
        end

        // Let any stray response show up
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
